/* hw/rtl/crt_pkg.sv */
// shared types, constants and helper functions for the table count sampler
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

  localparam int unsigned MAX_COUNT_DEF = 65535;
  localparam int unsigned CountW        = 16;
  localparam int unsigned ConcW         = 32;
  localparam int unsigned SumW          = 32;
  localparam int unsigned DataW         = 32;
  localparam int unsigned AddrW         = 3;

  // register index, taken from paddr[2]
  localparam logic REG_RNG_SEED = 1'b0;

  localparam logic [DataW-1:0] SEED_RESET = 32'd1;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [ConcW-1:0]  concentration;
    logic              last_in_column;
  } in_item_t;

  typedef struct packed {
    logic [SumW-1:0] column_sum;
    logic            saturated;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic draw;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic all_issued;
    logic last;
  } ctrl_sts_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  // a zero seed would lock the generator at zero
  function automatic logic [31:0] seed_value(input logic [31:0] s);
    return (s == 32'd0) ? 32'd1 : s;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/crt_table_count_sampler.sv */
// top level of the table count sampler: register port, controller and datapath
//
// Input channel (in_valid_i / in_ready_o / in_item_i) takes one beat per
// matrix entry: a count, the column concentration r (unsigned Q16.16) and
// a last-of-column mark. Each count gives that many Bernoulli draws with
// probability r/(r+i); accepted draws add to a saturating column sum.
// Output channel (out_valid_o / out_ready_i / out_item_o) gives one beat
// per column, after the beat that carries the last-of-column mark.
// An item is taken only while the controller is in intake; it then issues
// the clipped count of draws, one per cycle through the shared 32x32
// multiplier, retires the final compare, passes a flush state and returns
// to intake, loading the result register on the way on a last item.
// A column's result is valid once its last beat has gone through these
// steps and the output register is free.
// The result sits in an output register: further items are taken while it
// waits, and only the next column's result waits for it to be taken.
// The seed register sits at address 0 of the APB port; writing it reloads
// the generator. Reset sets the seed and generator to 1, clears the column
// sum and flags, and empties the output register.

`timescale 1ns / 1ps
`default_nettype none

module crt_table_count_sampler
  import crt_pkg::*;
#(
  parameter int unsigned MAX_COUNT = MAX_COUNT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_item_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  logic [DataW-1:0] seed_q;
  logic             seed_wr;
  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;

  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RNG_SEED);
  assign prdata  = (paddr[2] == REG_RNG_SEED) ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (seed_wr) begin
      seed_q <= pwdata;
    end
  end

  crt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  crt_dpath #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .seed_load_i (seed_wr),
    .seed_i      (pwdata),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/crt_ctrl.sv */
// controller state machine: item intake, draw issue, flush and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module crt_ctrl
  import crt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DRAW  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DRAW;
        end
      end
      S_DRAW: begin
        if (sts_i.all_issued) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.draw = 1'b1;
        end
      end
      // last compare retired in the cycle before, column sum has settled
      S_FLUSH: begin
        state_d = sts_i.last ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/crt_dpath.sv */
// datapath: xorshift generator, two-stage draw test, column accumulator, result register
`timescale 1ns / 1ps
`default_nettype none

module crt_dpath
  import crt_pkg::*;
#(
  parameter int unsigned MAX_COUNT = MAX_COUNT_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctrl_cmd_t  cmd_i,
  output ctrl_sts_t       sts_o,
  input  wire in_item_t   in_item_i,
  input  wire logic       seed_load_i,
  input  wire logic [31:0] seed_i,
  output out_item_t       out_item_o
);

  logic [CountW-1:0] count_q, idx_q;
  logic [ConcW-1:0]  conc_q;
  logic              last_q;
  logic [31:0]       rng_q;

  // stage one registers
  logic              v1_q;
  logic [63:0]       prod_q;
  logic [31:0]       u_q;
  logic              dh_q;

  logic [SumW-1:0]   sum_q;
  logic              sat_q;
  out_item_t         out_q;

  logic [CountW-1:0] count_clip;
  logic [31:0]       rng_next;
  logic [32:0]       denom;
  logic [32:0]       hi;
  logic              hit;

  assign count_clip = ({8'd0, in_item_i.count} > 24'(MAX_COUNT)) ?
                      CountW'(MAX_COUNT) : in_item_i.count;

  assign rng_next = xorshift32(rng_q);
  // r + i * 2^16, at most 33 bits
  assign denom    = {1'b0, conc_q} + {1'b0, idx_q, 16'd0};

  // u * d <= r * 2^32 with d split at bit 32
  assign hi  = {1'b0, prod_q[63:32]} + (dh_q ? {1'b0, u_q} : 33'd0);
  assign hit = (hi < {1'b0, conc_q}) ||
               ((hi == {1'b0, conc_q}) && (prod_q[31:0] == 32'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q <= SEED_RESET;
      idx_q <= '0;
      v1_q  <= 1'b0;
      sum_q <= '0;
      sat_q <= 1'b0;
    end else begin
      if (seed_load_i) begin
        rng_q <= seed_value(seed_i);
      end else if (cmd_i.draw) begin
        rng_q <= rng_next;
      end
      if (cmd_i.load_item) begin
        idx_q <= '0;
      end else if (cmd_i.draw) begin
        idx_q <= idx_q + CountW'(1);
      end
      v1_q <= cmd_i.draw;
      if (cmd_i.load_out) begin
        sum_q <= '0;
        sat_q <= 1'b0;
      end else if (v1_q && hit) begin
        if (sum_q == '1) begin
          sat_q <= 1'b1;
        end else begin
          sum_q <= sum_q + SumW'(1);
          if (sum_q == {{(SumW-1){1'b1}}, 1'b0}) begin
            sat_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      count_q <= count_clip;
      conc_q  <= in_item_i.concentration;
      last_q  <= in_item_i.last_in_column;
    end
    if (cmd_i.draw) begin
      prod_q <= 64'(rng_next) * 64'(denom[31:0]);
      u_q    <= rng_next;
      dh_q   <= denom[32];
    end
    if (cmd_i.load_out) begin
      out_q.column_sum <= sum_q;
      out_q.saturated  <= sat_q;
    end
  end

  assign sts_o.all_issued = (idx_q == count_q);
  assign sts_o.last       = last_q;
  assign out_item_o       = out_q;

endmodule

`default_nettype wire

/* hw/rtl/crt_checker.sv */
// port-level checks for the table count sampler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module crt_checker
  import crt_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o,
  input wire logic      pready
);

  // one item at a time: intake closes right after a beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // a new result only appears after an item has been worked on
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while intake was open");

  a_sat_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.saturated |-> out_item_o.column_sum == '1)
    else $error("saturated flag with non-full sum");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result beat dropped or changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind crt_table_count_sampler crt_checker u_crt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);

`default_nettype wire

/* bench/tb_crt_table_count_sampler.sv */
// self-checking bench for the table count sampler: directed rows, random columns, seed changes
`timescale 1ns / 1ps

module tb_crt_table_count_sampler;
  import crt_pkg::*;

  localparam int unsigned          WatchdogLimit = 200000;
  localparam logic [SumW-1:0]      SumMax        = '1;
  localparam logic [AddrW-1:0]     AddrSeed      = {REG_RNG_SEED, 2'b00};
  localparam logic [AddrW-1:0]     AddrUnmapped  = {~REG_RNG_SEED, 2'b00};

  // receiver stall modes
  localparam int unsigned RX_ALWAYS   = 0;
  localparam int unsigned RX_RANDOM   = 1;
  localparam int unsigned RX_PERIODIC = 2;

  typedef struct {
    logic [CountW-1:0] count;
    logic [ConcW-1:0]  conc;
    logic              last;
    bit                typed;
    logic [SumW-1:0]   typed_sum;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_item_t        out_item_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  crt_table_count_sampler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // sampler state as the bench sees it
  logic [31:0]     gen_state;
  logic [SumW-1:0] tables_so_far;
  logic            sum_pinned;
  out_item_t       column_sums_due[$];
  out_item_t       due_item;
  out_item_t       predicted;

  int unsigned mismatches;
  int unsigned columns_checked;
  int unsigned beats_sent;
  int unsigned draws_total;
  int unsigned seeds_used;
  int unsigned idle_cycles;

  // typed expectation for the beat currently on the bus
  bit              beat_typed;
  logic [SumW-1:0] beat_typed_sum;

  int unsigned burst_left;
  bit          no_idle;
  int unsigned rx_mode;
  int unsigned rx_left;
  int unsigned rx_period;
  int unsigned rx_hold;
  int unsigned rx_tick;

  stim_row_t stim_rows[14];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // exact integer form of u*(r+i) <= r with u = draw/2^32
  function automatic logic table_added(input logic [31:0] draw, input logic [ConcW-1:0] r,
                                       input logic [CountW-1:0] idx);
    logic [33:0] den;
    logic [65:0] lhs;
    den = {2'b00, r} + ({18'd0, idx} << 16);
    lhs = {34'd0, draw} * {32'd0, den};
    return lhs <= {2'b00, r, 32'd0};
  endfunction

  function automatic bit sample_tables(input in_item_t b, output out_item_t res);
    logic [31:0] x;
    int unsigned n;
    for (n = 0; n < 32'(b.count); n++) begin
      x = gen_state;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      gen_state = x;
      if (table_added(x, b.concentration, n[CountW-1:0])) begin
        if (tables_so_far == SumMax) sum_pinned = 1'b1;
        else tables_so_far = tables_so_far + SumW'(1);
        if (tables_so_far == SumMax) sum_pinned = 1'b1;
      end
    end
    draws_total += 32'(b.count);
    res.column_sum = tables_so_far;
    res.saturated  = sum_pinned;
    if (b.last_in_column) begin
      tables_so_far = '0;
      sum_pinned    = 1'b0;
    end
    return b.last_in_column;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, exp_v, act_v);
  endtask

  task automatic load_seed(input logic [31:0] s);
    gen_state = (s == 32'd0) ? 32'd1 : s;
    seeds_used++;
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check(input logic [AddrW-1:0] addr, input logic [DataW-1:0] want);
    logic [DataW-1:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) note_mismatch("seed readback", want, got);
  endtask

  // caller lowers valid at the negedge after the final beat
  task automatic send_beat(input in_item_t b, input bit typed, input logic [SumW-1:0] ts);
    int unsigned gap;
    if (burst_left == 0) begin
      no_idle    = ($urandom_range(0, 4) == 0);
      gap        = no_idle ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    in_item_i      <= b;
    beat_typed     = typed;
    beat_typed_sum = ts;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained;
    while (column_sums_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [ConcW-1:0] pick_conc;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0001_0000;
      3, 4:    return $urandom;
      default: return $urandom_range(1, 32'h0008_0000);
    endcase
  endfunction

  // whole columns; one in ten is noisy with shifting r and stray last marks
  task automatic run_columns(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    int unsigned roll;
    logic [ConcW-1:0] conc;
    bit noisy;
    in_item_t b;
    sent = 0;
    while (sent < n_items) begin
      len   = $urandom_range(1, 8);
      noisy = ($urandom_range(0, 9) == 0);
      conc  = pick_conc();
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(0, 999);
        if (roll < 3) b.count = CountW'($urandom_range(32768, 65535));
        else if (roll < 150) b.count = CountW'($urandom_range(13, 300));
        else if (roll < 250) b.count = '0;
        else b.count = CountW'($urandom_range(1, 12));
        b.concentration  = noisy ? pick_conc() : conc;
        b.last_in_column = (k == len - 1) ? 1'b1 : (noisy ? 1'($urandom_range(0, 1)) : 1'b0);
        send_beat(b, 1'b0, '0);
        sent++;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // receiver: always ready, ready at random about 60 percent of the time, or a periodic stall
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode   = $urandom_range(RX_ALWAYS, RX_PERIODIC);
      rx_left   = $urandom_range(50, 400);
      rx_period = $urandom_range(2, 14);
      rx_hold   = $urandom_range(1, rx_period - 1);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= ($urandom_range(0, 99) < 60);
      default:   out_ready_i <= ((rx_tick % rx_period) >= rx_hold);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;

    if (in_valid_i && in_ready_o) begin
      beats_sent++;
      if (sample_tables(in_item_i, predicted)) begin
        if (beat_typed) column_sums_due.push_back('{beat_typed_sum, 1'b0});
        else column_sums_due.push_back(predicted);
      end
    end

    if (out_valid_o && out_ready_i) begin
      if (column_sums_due.size() == 0) begin
        note_mismatch("unexpected column beat", '0, out_item_o.column_sum);
      end else begin
        due_item = column_sums_due.pop_front();
        columns_checked++;
        if (out_item_o.column_sum !== due_item.column_sum)
          note_mismatch("column_sum", due_item.column_sum, out_item_o.column_sum);
        if (out_item_o.saturated !== due_item.saturated)
          note_mismatch("saturated", 32'(due_item.saturated), 32'(out_item_o.saturated));
      end
    end

    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d columns still due",
               idle_cycles, column_sums_due.size());
      $display("tb_crt_table_count_sampler: FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] phase_seeds[4];
    int unsigned r;
    int unsigned p;
    in_item_t b;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;

    gen_state      = SEED_RESET;
    tables_so_far  = '0;
    sum_pinned     = 1'b0;
    mismatches     = 0;
    columns_checked = 0;
    beats_sent     = 0;
    draws_total    = 0;
    seeds_used     = 1;
    idle_cycles    = 0;
    beat_typed     = 1'b0;
    beat_typed_sum = '0;
    burst_left     = 0;
    no_idle        = 1'b0;
    rx_mode        = RX_ALWAYS;
    rx_left        = 0;
    rx_period      = 2;
    rx_hold        = 1;
    rx_tick        = 0;

    // count, r, last, typed, typed sum
    stim_rows = '{
      '{16'd0,     32'h0001_0000, 1'b1, 1'b1, 32'd0},  // empty column
      '{16'd1,     32'h0001_0000, 1'b1, 1'b1, 32'd1},  // first draw always seats
      '{16'd1,     32'hFFFF_FFFF, 1'b1, 1'b1, 32'd1},
      '{16'd1,     32'h0000_0000, 1'b1, 1'b1, 32'd1},
      '{16'd5,     32'h0000_0000, 1'b1, 1'b1, 32'd1},  // zero r: only draw 0 seats
      '{16'hFFFF,  32'h0000_0000, 1'b1, 1'b1, 32'd1},
      '{16'd3,     32'h0001_0000, 1'b0, 1'b0, 32'd0},
      '{16'd0,     32'h0001_0000, 1'b0, 1'b0, 32'd0},
      '{16'd4,     32'h0000_8000, 1'b1, 1'b0, 32'd0},
      '{16'd20,    32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0},
      '{16'd10,    32'h0000_0001, 1'b1, 1'b0, 32'd0},
      '{16'hFFFF,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0},
      '{16'd2,     32'h0003_0000, 1'b0, 1'b0, 32'd0},
      '{16'd1,     32'h0001_0000, 1'b1, 1'b0, 32'd0}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apb_check(AddrSeed, SEED_RESET);

    for (r = 0; r < $size(stim_rows); r++) begin
      b.count          = stim_rows[r].count;
      b.concentration  = stim_rows[r].conc;
      b.last_in_column = stim_rows[r].last;
      send_beat(b, stim_rows[r].typed, stim_rows[r].typed_sum);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    beat_typed = 1'b0;
    wait_drained();

    // unmapped register: write must be dropped, seed unchanged
    apb_write(AddrUnmapped, $urandom);
    apb_check(AddrSeed, SEED_RESET);

    phase_seeds = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h0000_0001};
    for (p = 0; p < 4; p++) begin
      apb_write(AddrSeed, phase_seeds[p]);
      load_seed(phase_seeds[p]);
      apb_check(AddrSeed, phase_seeds[p]);
      run_columns(430);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d beats (%0d draws) over %0d seeds, %0d column sums checked",
             beats_sent, draws_total, seeds_used, columns_checked);
    $display("mismatches: %0d, column sums left waiting: %0d",
             mismatches, column_sums_due.size());
    if (mismatches == 0 && column_sums_due.size() == 0)
      $display("tb_crt_table_count_sampler: PASS");
    else
      $display("tb_crt_table_count_sampler: FAIL");
    $finish;
  end

endmodule

/* crt_table_count_sampler.f */
hw/rtl/crt_pkg.sv
hw/rtl/crt_ctrl.sv
hw/rtl/crt_dpath.sv
hw/rtl/crt_table_count_sampler.sv
hw/rtl/crt_checker.sv
bench/tb_crt_table_count_sampler.sv
